>>> rtl/mfas_pkg.sv
// ----------------------------------------------------------------------------
// mfas_pkg
// Shared widths, action codes and the operand check for the mixed fraction
// add/subtract block.
// ----------------------------------------------------------------------------
package mfas_pkg;

  localparam int W_IN   = 16;
  localparam int W_ACT  = 2;
  localparam int W_ACC  = 50;
  localparam int W_DEN  = 32;
  localparam int W_NUM  = 34;
  localparam int W_RDEN = 33;
  localparam int W_CNTM = 4;
  localparam int W_CNTD = 6;
  localparam int W_K    = 5;

  localparam logic [W_ACT-1:0] ACT_NORM = 2'd0;
  localparam logic [W_ACT-1:0] ACT_ADD  = 2'd1;
  localparam logic [W_ACT-1:0] ACT_SUB  = 2'd2;

  function automatic logic opnd_ok(logic signed [W_IN-1:0] w,
                                   logic signed [W_IN-1:0] n,
                                   logic [W_IN-1:0] d);
    return !(((n != '0) && (d == '0)) || (n[W_IN-1] && (w != '0)));
  endfunction

endpackage

>>> rtl/mfas_smac.sv
// ----------------------------------------------------------------------------
// mfas_smac
// Bit-serial multiply-accumulate: acc = init + a * b, one bit of b per cycle.
// ----------------------------------------------------------------------------
module mfas_smac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mfas_pkg::W_ACC-1:0] a,
  input  logic [mfas_pkg::W_IN-1:0]         b,
  input  logic signed [mfas_pkg::W_ACC-1:0] init,
  output logic                              done,
  output logic signed [mfas_pkg::W_ACC-1:0] acc
);
  import mfas_pkg::*;

  localparam logic [W_CNTM-1:0] CNT_LAST = W_CNTM'(W_IN - 1);

  logic                     run_r;
  logic                     done_r;
  logic [W_CNTM-1:0]        cnt_r;
  logic signed [W_ACC-1:0]  a_r;
  logic [W_IN-1:0]          b_r;
  logic signed [W_ACC-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_LAST);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_LAST) run_r <= 1'b0;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= init;
    end else if (run_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r <<< 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

>>> rtl/mfas_div.sv
// ----------------------------------------------------------------------------
// mfas_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfas_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mfas_pkg::W_ACC-1:0]  dividend,
  input  logic [mfas_pkg::W_DEN-1:0]  divisor,
  output logic                        done,
  output logic [mfas_pkg::W_ACC-1:0]  quo,
  output logic [mfas_pkg::W_DEN-1:0]  rem
);
  import mfas_pkg::*;

  localparam logic [W_CNTD-1:0] CNT_LAST = W_CNTD'(W_ACC - 1);

  logic               run_r;
  logic               done_r;
  logic [W_CNTD-1:0]  cnt_r;
  logic [W_ACC-1:0]   q_r;
  logic [W_DEN-1:0]   rem_r;
  logic [W_DEN-1:0]   div_r;
  logic [W_DEN:0]     trial;
  logic               ge;
  logic [W_DEN:0]     diff;

  assign trial = {rem_r, q_r[W_ACC-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_LAST);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_LAST) run_r <= 1'b0;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff[W_DEN-1:0] : trial[W_DEN-1:0];
      q_r   <= {q_r[W_ACC-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

>>> rtl/mfas_gcd.sv
// ----------------------------------------------------------------------------
// mfas_gcd
// Binary GCD of two nonzero values, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module mfas_gcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mfas_pkg::W_DEN-1:0]  a,
  input  logic [mfas_pkg::W_DEN-1:0]  b,
  output logic                        done,
  output logic [mfas_pkg::W_DEN-1:0]  g
);
  import mfas_pkg::*;

  logic             run_r;
  logic             done_r;
  logic [W_DEN-1:0] a_r;
  logic [W_DEN-1:0] b_r;
  logic [W_K-1:0]   k_r;
  logic [W_DEN-1:0] g_r;
  logic             fin;

  assign fin = (a_r == '0) || (b_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && fin;
      if (start) run_r <= 1'b1;
      else if (run_r && fin) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      k_r <= '0;
    end else if (run_r) begin
      if (fin) begin
        g_r <= (a_r | b_r) << k_r;
      end else if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= a_r - b_r;
      end else begin
        b_r <= b_r - a_r;
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

>>> rtl/mixed_fraction_add_sub.sv
// ----------------------------------------------------------------------------
// mixed_fraction_add_sub
// Mixed number normalize/add/subtract, reduced to lowest terms.
// An invalid item goes straight to the output register stage; a valid one runs
// two rounds of 16-step serial multiplies and a 50-step serial divide and,
// when the remainder is nonzero, the binary GCD loop and then two 50-step
// serial divides side by side.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is handed to the output register. Reset clears all control state.
// ----------------------------------------------------------------------------
module mixed_fraction_add_sub (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mfas_pkg::W_ACT-1:0]          in_action,
  input  logic signed [mfas_pkg::W_IN-1:0]    in_first_whole,
  input  logic signed [mfas_pkg::W_IN-1:0]    in_first_numerator,
  input  logic [mfas_pkg::W_IN-1:0]           in_first_denominator,
  input  logic signed [mfas_pkg::W_IN-1:0]    in_second_whole,
  input  logic signed [mfas_pkg::W_IN-1:0]    in_second_numerator,
  input  logic [mfas_pkg::W_IN-1:0]           in_second_denominator,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mfas_pkg::W_ACC-1:0]   out_result_whole,
  output logic signed [mfas_pkg::W_NUM-1:0]   out_result_numerator,
  output logic [mfas_pkg::W_RDEN-1:0]         out_result_denominator,
  output logic                                out_error
);
  import mfas_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]              state_r;
  logic [W_ACT-1:0]        act_r;
  logic [W_IN-1:0]         d1p_r;
  logic [W_IN-1:0]         d2p_r;
  logic                    neg_r;
  logic [W_DEN-1:0]        den_r;
  logic [W_DEN-1:0]        r_r;
  logic [W_ACC-1:0]        q_r;
  logic signed [W_ACC-1:0] st_whole_r;
  logic signed [W_NUM-1:0] st_num_r;
  logic [W_RDEN-1:0]       st_den_r;
  logic                    st_err_r;
  logic                    out_valid_r;
  logic signed [W_ACC-1:0] out_whole_r;
  logic signed [W_NUM-1:0] out_num_r;
  logic [W_RDEN-1:0]       out_den_r;
  logic                    out_err_r;

  logic                    acc_in;
  logic                    out_load;
  logic                    ok;
  logic [W_IN-1:0]         d1p;
  logic [W_IN-1:0]         d2p;
  logic signed [W_ACC-1:0] n1_ext;
  logic signed [W_ACC-1:0] n2_ext;
  logic [W_IN-1:0]         b_cross;

  logic                    x_start, y_start, z_start;
  logic signed [W_ACC-1:0] x_a, y_a, x_init, y_init;
  logic [W_IN-1:0]         x_b, y_b;
  logic                    x_done, y_done, z_done;
  logic signed [W_ACC-1:0] x_acc, y_acc, z_acc;

  logic signed [W_ACC-1:0] num_c;
  logic [W_ACC-1:0]        mag_c;

  logic                    da_start, db_start, da_done, db_done;
  logic [W_ACC-1:0]        da_dvd, da_q, db_q;
  logic [W_DEN-1:0]        da_dvs, da_r, db_r;
  logic                    g_start, g_done;
  logic [W_DEN-1:0]        g_val;
  logic [W_ACC-1:0]        whole_c;
  logic [W_NUM-1:0]        rn_c;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign ok = opnd_ok(in_first_whole, in_first_numerator, in_first_denominator)
           && ((in_action == ACT_NORM)
               || opnd_ok(in_second_whole, in_second_numerator, in_second_denominator))
           && ((in_action == ACT_NORM) || (in_action == ACT_ADD)
               || (in_action == ACT_SUB));

  assign d1p    = (in_first_denominator == '0) ? W_IN'(1) : in_first_denominator;
  assign d2p    = (in_second_denominator == '0) ? W_IN'(1) : in_second_denominator;
  assign n1_ext = W_ACC'(in_first_numerator);
  assign n2_ext = W_ACC'(in_second_numerator);
  assign b_cross = (act_r == ACT_NORM) ? W_IN'(1) : d2p_r;

  assign x_start = (acc_in && ok) || ((state_r == S_MUL1) && x_done);
  assign y_start = x_start;
  assign z_start = (state_r == S_MUL1) && x_done;
  assign x_a     = (state_r == S_IDLE) ? W_ACC'(in_first_whole) : x_acc;
  assign y_a     = (state_r == S_IDLE) ? W_ACC'(in_second_whole) : y_acc;
  assign x_b     = (state_r == S_IDLE) ? d1p : b_cross;
  assign y_b     = (state_r == S_IDLE) ? d2p : d1p_r;
  assign x_init  = (state_r != S_IDLE) ? '0 :
                   (in_first_whole[W_IN-1] ? -n1_ext : n1_ext);
  assign y_init  = (state_r != S_IDLE) ? '0 :
                   (in_second_whole[W_IN-1] ? -n2_ext : n2_ext);

  mfas_smac u_mac_x (
    .clk (clk), .rst_n (rst_n), .start (x_start), .a (x_a), .b (x_b),
    .init (x_init), .done (x_done), .acc (x_acc)
  );

  mfas_smac u_mac_y (
    .clk (clk), .rst_n (rst_n), .start (y_start), .a (y_a), .b (y_b),
    .init (y_init), .done (y_done), .acc (y_acc)
  );

  mfas_smac u_mac_z (
    .clk (clk), .rst_n (rst_n), .start (z_start), .a (W_ACC'(d1p_r)),
    .b (b_cross), .init ('0), .done (z_done), .acc (z_acc)
  );

  always_comb begin
    case (act_r)
      ACT_ADD: num_c = x_acc + y_acc;
      ACT_SUB: num_c = x_acc - y_acc;
      default: num_c = x_acc;
    endcase
  end
  assign mag_c = num_c[W_ACC-1] ? W_ACC'(-num_c) : W_ACC'(num_c);

  assign da_start = ((state_r == S_MUL2) && z_done) || ((state_r == S_GCD) && g_done);
  assign db_start = (state_r == S_GCD) && g_done;
  assign da_dvd   = (state_r == S_MUL2) ? mag_c : W_ACC'(r_r);
  assign da_dvs   = (state_r == S_MUL2) ? z_acc[W_DEN-1:0] : g_val;
  assign g_start  = (state_r == S_DIV1) && da_done && (da_r != '0);

  mfas_div u_div_a (
    .clk (clk), .rst_n (rst_n), .start (da_start), .dividend (da_dvd),
    .divisor (da_dvs), .done (da_done), .quo (da_q), .rem (da_r)
  );

  mfas_div u_div_b (
    .clk (clk), .rst_n (rst_n), .start (db_start), .dividend (W_ACC'(den_r)),
    .divisor (g_val), .done (db_done), .quo (db_q), .rem (db_r)
  );

  mfas_gcd u_gcd (
    .clk (clk), .rst_n (rst_n), .start (g_start), .a (den_r), .b (da_r),
    .done (g_done), .g (g_val)
  );

  assign whole_c = neg_r ? -q_r : q_r;
  assign rn_c    = (neg_r && (q_r == '0)) ? -da_q[W_NUM-1:0] : da_q[W_NUM-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc_in) state_r <= ok ? S_MUL1 : S_DONE;
        end
        S_MUL1: if (x_done) state_r <= S_MUL2;
        S_MUL2: if (z_done) state_r <= S_DIV1;
        S_DIV1: begin
          if (da_done) state_r <= (da_r == '0) ? S_DONE : S_GCD;
        end
        S_GCD:  if (g_done) state_r <= S_DIV2;
        S_DIV2: if (da_done) state_r <= S_DONE;
        S_DONE: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      act_r      <= in_action;
      d1p_r      <= d1p;
      d2p_r      <= d2p;
      st_whole_r <= '0;
      st_num_r   <= '0;
      st_den_r   <= '0;
      st_err_r   <= !ok;
    end
    if ((state_r == S_MUL2) && z_done) begin
      neg_r <= num_c[W_ACC-1];
      den_r <= z_acc[W_DEN-1:0];
    end
    if ((state_r == S_DIV1) && da_done) begin
      q_r        <= da_q;
      r_r        <= da_r;
      st_whole_r <= neg_r ? -da_q : da_q;
    end
    if ((state_r == S_DIV2) && da_done) begin
      st_whole_r <= whole_c;
      st_num_r   <= rn_c;
      st_den_r   <= db_q[W_RDEN-1:0];
    end
    if (out_load) begin
      out_whole_r <= st_whole_r;
      out_num_r   <= st_num_r;
      out_den_r   <= st_den_r;
      out_err_r   <= st_err_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_whole       = out_whole_r;
  assign out_result_numerator   = out_num_r;
  assign out_result_denominator = out_den_r;
  assign out_error              = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> ((out_result_whole == '0)
      && (out_result_numerator == '0) && (out_result_denominator == '0)))
    else $error("error item carries nonzero fields");

  a_den_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_denominator == '0)) |-> (out_result_numerator == '0))
    else $error("numerator without denominator");

  a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && !ok) |=> (state_r == S_DONE))
    else $error("invalid item not sent straight to output");

  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV1) && da_done) |-> (da_r < den_r))
    else $error("remainder not below denominator");

  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2) |-> ((da_done == db_done) && (!db_done || (db_r == '0))))
    else $error("reduction dividers out of step");

  a_mac_sync: assert property (@(posedge clk) disable iff (!rst_n)
    x_done == y_done)
    else $error("cross multipliers out of step");

endmodule

>>> tb/mixed_fraction_add_sub_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mixed_fraction_add_sub_test
// Drives directed and random mixed-number items (normalize, add, subtract,
// invalid operands, unused action) with random gaps on both sides and checks
// every result item against an in-bench predictor of the reduced fraction.
// ----------------------------------------------------------------------------
module mixed_fraction_add_sub_test;
  import mfas_pkg::*;

  localparam logic [W_ACT-1:0] ACT_BAD = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [W_ACT-1:0] action;
    logic signed [W_IN-1:0] w1, n1;
    logic [W_IN-1:0] d1;
    logic signed [W_IN-1:0] w2, n2;
    logic [W_IN-1:0] d2;
  } mixed_item_t;

  typedef struct packed {
    logic signed [W_ACC-1:0] whole;
    logic signed [W_NUM-1:0] num;
    logic [W_RDEN-1:0] den;
    logic err;
  } reduced_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W_ACT-1:0] in_action = '0;
  logic signed [W_IN-1:0] in_first_whole = '0, in_first_numerator = '0;
  logic [W_IN-1:0] in_first_denominator = '0;
  logic signed [W_IN-1:0] in_second_whole = '0, in_second_numerator = '0;
  logic [W_IN-1:0] in_second_denominator = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W_ACC-1:0] out_result_whole;
  logic signed [W_NUM-1:0] out_result_numerator;
  logic [W_RDEN-1:0] out_result_denominator;
  logic out_error;
  logic accepted = 1'b0;

  mixed_item_t pending_items[$];
  reduced_t expected_sums[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;

  always #4 clk = ~clk;

  mixed_fraction_add_sub u_top (.*);

  function automatic logic to_improper(input logic signed [W_IN-1:0] w,
                                       input logic signed [W_IN-1:0] n,
                                       input logic [W_IN-1:0] d,
                                       output longint num, output longint den);
    longint wl, nl;
    wl = w;
    nl = n;
    num = 0;
    den = 1;
    if ((n != 0 && d == 0) || (n < 0 && w != 0)) return 1'b0;
    den = (d == 0) ? 1 : longint'(d);
    num = (wl < 0) ? wl * den - nl : wl * den + nl;
    return 1'b1;
  endfunction

  function automatic reduced_t reduce_mixed(input mixed_item_t it);
    reduced_t r;
    longint a, b, c, e, num, den;
    logic ok;
    longint unsigned mag, q, rem, x, y, t, rn;
    r = '0;
    ok = to_improper(it.w1, it.n1, it.d1, a, b);
    if (it.action == ACT_ADD || it.action == ACT_SUB)
      ok = to_improper(it.w2, it.n2, it.d2, c, e) && ok;
    if (it.action == ACT_BAD) ok = 1'b0;
    if (!ok) begin
      r.err = 1'b1;
      return r;
    end
    if (it.action == ACT_NORM) begin
      num = a;
      den = b;
    end else begin
      den = b * e;
      num = (it.action == ACT_ADD) ? a * e + c * b : a * e - c * b;
    end
    mag = (num < 0) ? -num : num;
    q = mag / den;
    rem = mag % den;
    r.whole = W_ACC'((num < 0) ? -longint'(q) : longint'(q));
    if (rem != 0) begin
      x = den;
      y = rem;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      rn = rem / x;
      r.num = W_NUM'((num < 0 && q == 0) ? -longint'(rn) : longint'(rn));
      r.den = W_RDEN'(den / x);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic mixed_item_t random_item();
    mixed_item_t it;
    int k;
    it = '0;
    k = $urandom_range(0, 9);
    it.action = (k == 0) ? ACT_BAD : W_ACT'($urandom_range(0, 2));
    it.w1 = W_IN'($urandom);
    it.w2 = W_IN'($urandom);
    it.d1 = W_IN'($urandom);
    it.d2 = W_IN'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.w1 = W_IN'(int'($urandom_range(0, 20)) - 10);
      it.w2 = W_IN'(int'($urandom_range(0, 20)) - 10);
      it.d1 = W_IN'($urandom_range(0, 12));
      it.d2 = W_IN'($urandom_range(0, 12));
    end
    it.n1 = (it.d1 == 0) ? 16'sd0 : W_IN'($urandom_range(0, int'(it.d1) - 1));
    it.n2 = (it.d2 == 0) ? 16'sd0 : W_IN'($urandom_range(0, int'(it.d2) - 1));
    if (it.w1 == 0 && $urandom_range(0, 1)) it.n1 = -it.n1;
    if (it.w2 == 0 && $urandom_range(0, 1)) it.n2 = -it.n2;
    if ($urandom_range(0, 11) == 0) it.n1 = W_IN'($urandom);
    if ($urandom_range(0, 11) == 0) it.n2 = W_IN'($urandom);
    return it;
  endfunction

  function automatic int random_gap();
    return ($urandom_range(0, 19) == 0) ? int'($urandom_range(20, 150))
                                        : int'($urandom_range(0, 2));
  endfunction

  initial begin
    pending_items.push_back({ACT_NORM, 16'sd3, 16'sd5, 16'd4, 16'sd0, 16'sd0, 16'd0});
    pending_items.push_back({ACT_NORM, 16'sh8000, 16'sd0, 16'd0, 16'sd0, 16'sd0, 16'd0});
    pending_items.push_back({ACT_NORM, 16'sd0, 16'sh8000, 16'd65535, 16'sd0, 16'sd0, 16'd0});
    pending_items.push_back({ACT_NORM, 16'sd0, 16'sd6, 16'd4, 16'sd1, 16'sd1, 16'd0});
    pending_items.push_back({ACT_NORM, 16'sd2, 16'sd1, 16'd0, 16'sd0, 16'sd0, 16'd0});
    pending_items.push_back({ACT_NORM, 16'sd2, -16'sd1, 16'd3, 16'sd0, 16'sd0, 16'd0});
    pending_items.push_back({ACT_ADD, 16'sd32767, 16'sd32767, 16'd65535,
                             16'sd32767, 16'sd32767, 16'd65534});
    pending_items.push_back({ACT_SUB, 16'sh8000, 16'sd32767, 16'd65535,
                             16'sd32767, 16'sd32767, 16'd65534});
    pending_items.push_back({ACT_ADD, 16'sd0, -16'sd1, 16'd2, 16'sd0, 16'sd1, 16'd2});
    pending_items.push_back({ACT_SUB, 16'sd1, 16'sd1, 16'd3, 16'sd1, 16'sd2, 16'd3});
    pending_items.push_back({ACT_ADD, 16'sd4, 16'sd0, 16'd0, -16'sd2, 16'sd0, 16'd0});
    pending_items.push_back({ACT_SUB, 16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd5, 16'd0});
    pending_items.push_back({ACT_ADD, 16'sd1, 16'sd0, 16'd5, -16'sd1, -16'sd2, 16'd5});
    pending_items.push_back({ACT_BAD, 16'sd1, 16'sd1, 16'd2, 16'sd1, 16'sd1, 16'd2});
    pending_items.push_back({ACT_SUB, -16'sd1, 16'sd1, 16'd2, 16'sd0, -16'sd3, 16'd4});
    pending_items.push_back({ACT_ADD, 16'sd0, 16'sd0, 16'd65535, 16'sd0, 16'sd0, 16'd1});
    repeat (700) pending_items.push_back(random_item());
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
  end

  // hold off once, early, so the block fills and stalls its input
  always @(negedge clk) begin
    if (cycles == 2000) hold_off <= 3000;
    else if (hold_off > 0) hold_off <= hold_off - 1;
    if (!rst_n || hold_off > 1 || cycles == 2000) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap <= random_gap();
    end
  end

  always @(posedge clk) begin
    accepted <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      expected_sums.push_back(reduce_mixed({in_action, in_first_whole, in_first_numerator,
                                            in_first_denominator, in_second_whole,
                                            in_second_numerator, in_second_denominator}));
    end
  end

  // driver: advance at falling edge after an accept
  always @(negedge clk) begin
    mixed_item_t it;
    if (rst_n) begin
      if (accepted || !in_valid) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          {in_action, in_first_whole, in_first_numerator, in_first_denominator,
           in_second_whole, in_second_numerator, in_second_denominator} <= it;
          in_valid <= 1'b1;
          send_gap <= random_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reduced_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_sums.pop_front();
        if (out_result_whole !== want.whole)
          report_mismatch("whole", longint'(out_result_whole), longint'(want.whole));
        if (out_result_numerator !== want.num)
          report_mismatch("numerator", longint'(out_result_numerator), longint'(want.num));
        if (out_result_denominator !== want.den)
          report_mismatch("denominator", longint'(out_result_denominator),
                          longint'(want.den));
        if (out_error !== want.err)
          report_mismatch("error", longint'(out_error), longint'(want.err));
      end
    end
  end

  initial begin
    wait (rst_n);
    @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_sums.size() > 0)
      @(negedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end
endmodule
